// ===== src/mbps_pkg.sv =====
package mbps_pkg;

  localparam int MAX_PATTERN  = 16;
  localparam int OFFSET_WIDTH = 32;
  localparam int COUNT_WIDTH  = 32;
  localparam int PAT_W        = MAX_PATTERN * 8;
  localparam int LEN_W        = 5;

  typedef enum logic [2:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_WILDCARD     = 3'd2,
    REG_LENGTH       = 3'd3,
    REG_START        = 3'd4,
    REG_END          = 3'd5,
    REG_FIND_ALL     = 3'd6,
    REG_LIMIT        = 3'd7
  } cfg_reg_t;

  // Control that every cell of the window sees in the same cycle.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic                    match_found;
    logic [31:0]             match_offset;
    logic [63:0]             matched_low;
    logic [63:0]             matched_high;
    logic                    scan_done;
  } result_t;

endpackage

// ===== src/mbps_cell.sv =====
module mbps_cell (
  input  logic                clk,
  input  logic                rst,
  input  mbps_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]          byte_in,
  input  logic [7:0]          pat_byte,
  input  logic                care,
  output logic [7:0]          byte_out,
  output logic                byte_ok
);

  logic [7:0] held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (ctrl.shift) begin
      held <= ctrl.clear ? 8'h00 : byte_in;
    end
  end

  assign byte_out = held;

  // The compare looks at the byte arriving from the neighbour, which is this
  // cell's content once the current beat has shifted in.
  assign byte_ok = !care || (byte_in == pat_byte);

endmodule

// ===== src/mbps_out_stage.sv =====
module mbps_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  mbps_pkg::result_t load_data,
  output logic              can_take,
  output logic              out_valid,
  input  logic              out_ready,
  output mbps_pkg::result_t out_data
);

  logic              main_valid;
  logic              skid_valid;
  mbps_pkg::result_t main_data;
  mbps_pkg::result_t skid_data;
  logic              out_fire;

  assign out_fire  = main_valid && out_ready;
  assign can_take  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (load) begin
      if (main_valid && !out_ready) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end else if (out_fire) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        main_data <= skid_data;
      end
    end else if (load) begin
      if (main_valid && !out_ready) begin
        skid_data <= load_data;
      end else begin
        main_data <= load_data;
      end
    end
  end

endmodule

// ===== src/masked_byte_pattern_scanner.sv =====
// Masked byte pattern scanner.
// Bytes of a buffer arrive one per beat on the input channel (data_byte,
// last_byte marking the final byte). Every accepted byte yields exactly one
// result beat: match_found with the start offset and the matched bytes when
// the most recent pattern_length bytes equal the pattern, wildcard bytes
// excepted, and scan_done echoing last_byte.
// Registers are written over the cfg channel (cfg_index, cfg_data), which is
// always ready; write them only while no byte is in flight.
// The result of an accepted byte is registered in the output stage. Throughput
// is one byte per cycle while in_ready is high, set by the combinational
// masked compare across the sixteen window cells plus the offset compares.
// A two-entry output stage lets the block take a byte while a result waits;
// in_ready falls only when both entries are held by a stalled receiver.
// Reset restores the register defaults and clears the window, the byte
// position, the match count and the stop flag; the last byte of a buffer
// clears the same scan state.
module masked_byte_pattern_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        match_found,
  output logic [31:0] match_offset,
  output logic [63:0] matched_low,
  output logic [63:0] matched_high,
  output logic        scan_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int MAXP = mbps_pkg::MAX_PATTERN;
  localparam int PW   = mbps_pkg::PAT_W;
  localparam int LW   = mbps_pkg::LEN_W;
  localparam int OW   = mbps_pkg::OFFSET_WIDTH;
  localparam int CW   = mbps_pkg::COUNT_WIDTH;

  // Configuration registers
  logic [63:0]     pattern_low;
  logic [63:0]     pattern_high;
  logic [15:0]     wildcard_mask;
  logic [LW-1:0]   pattern_length;
  logic [31:0]     start_offset;
  logic [31:0]     end_offset;
  logic            find_all;
  logic [31:0]     match_limit;

  // Scan state
  logic [OW-1:0]   byte_position;
  logic [CW-1:0]   match_count;
  logic            scan_stopped;

  logic            in_fire;
  logic            hit;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      wildcard_mask  <= '0;
      pattern_length <= LW'(1);
      start_offset   <= '0;
      end_offset     <= '0;
      find_all       <= 1'b1;
      match_limit    <= '0;
    end else if (cfg_valid) begin
      case (mbps_pkg::cfg_reg_t'(cfg_index))
        mbps_pkg::REG_PATTERN_LOW:  pattern_low    <= cfg_data;
        mbps_pkg::REG_PATTERN_HIGH: pattern_high   <= cfg_data;
        mbps_pkg::REG_WILDCARD:     wildcard_mask  <= cfg_data[15:0];
        mbps_pkg::REG_LENGTH:       pattern_length <= cfg_data[LW-1:0];
        mbps_pkg::REG_START:        start_offset   <= cfg_data[31:0];
        mbps_pkg::REG_END:          end_offset     <= cfg_data[31:0];
        mbps_pkg::REG_FIND_ALL:     find_all       <= cfg_data[0];
        mbps_pkg::REG_LIMIT:        match_limit    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Pattern alignment: cell k compares against pattern byte n-1-k. Reversing
  // the pattern and shifting it down by MAX_PATTERN-n bytes gives that order
  // with a plain shifter instead of a per-cell selector.
  logic            len_ok;
  logic [LW-1:0]   len_m1;
  logic [LW-1:0]   align_sh;
  logic [PW-1:0]   pat_all;
  logic [PW-1:0]   pat_rev;
  logic [PW-1:0]   pat_aligned;
  logic [MAXP-1:0] mask_rev;
  logic [MAXP-1:0] mask_aligned;
  logic [MAXP-1:0] used_aligned;

  assign len_ok   = (pattern_length != '0) && (pattern_length <= LW'(MAXP));
  assign len_m1   = pattern_length - LW'(1);
  assign align_sh = LW'(MAXP) - pattern_length;
  assign pat_all  = PW'({pattern_high, pattern_low});

  for (genvar i = 0; i < MAXP; i++) begin : g_rev
    assign pat_rev[8*i +: 8] = pat_all[8*(MAXP-1-i) +: 8];
    assign mask_rev[i]       = wildcard_mask[MAXP-1-i];
  end

  assign pat_aligned  = pat_rev >> {align_sh, 3'b000};
  assign mask_aligned = mask_rev >> align_sh;
  assign used_aligned = {MAXP{1'b1}} >> align_sh;

  // Window: a chain of byte cells, newest byte in cell 0.
  mbps_pkg::cell_ctrl_t  ctrl;
  logic [7:0]            win_in  [MAXP];
  logic [7:0]            win_out [MAXP];
  logic [MAXP-1:0]       cell_ok;

  assign ctrl.shift = in_fire;
  assign ctrl.clear = last_byte;

  for (genvar k = 0; k < MAXP; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign win_in[k] = data_byte;
    end else begin : g_link
      assign win_in[k] = win_out[k-1];
    end

    mbps_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .byte_in  (win_in[k]),
      .pat_byte (pat_aligned[8*k +: 8]),
      .care     (used_aligned[k] && !mask_aligned[k]),
      .byte_out (win_out[k]),
      .byte_ok  (cell_ok[k])
    );
  end

  // Offset window test: the match's first byte against start_offset, its last byte against end_offset.
  logic [OW:0]     first_pos;
  logic            range_ok;

  assign first_pos = {1'b0, byte_position} - (OW+1)'(len_m1);
  assign range_ok  = !first_pos[OW] &&
                     (first_pos[OW-1:0] >= start_offset) &&
                     ((end_offset == '0) || (byte_position < end_offset));
  assign hit       = len_ok && !scan_stopped && range_ok && (&cell_ok);

  // Matched bytes: byte j comes from cell n-1-j; unused bytes fall out as zero.
  logic [PW-1:0]   win_rev;
  logic [PW-1:0]   win_aligned;
  logic [127:0]    matched_all;

  for (genvar i = 0; i < MAXP; i++) begin : g_wrev
    assign win_rev[8*i +: 8] = win_in[MAXP-1-i];
  end

  assign win_aligned = win_rev >> {align_sh, 3'b000};
  assign matched_all = 128'(win_aligned);

  // Match counting and stop flag.
  logic [CW-1:0]   count_inc;
  logic [31:0]     limit_eff;
  logic            stop_set;

  assign count_inc = (match_count != '1) ? match_count + CW'(1) : match_count;
  assign limit_eff = (match_limit == '0) ? 32'd1 : match_limit;
  assign stop_set  = !find_all && (count_inc >= limit_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      match_count   <= '0;
      scan_stopped  <= 1'b0;
    end else if (in_fire) begin
      if (last_byte) begin
        byte_position <= '0;
        match_count   <= '0;
        scan_stopped  <= 1'b0;
      end else begin
        if (byte_position != '1) begin
          byte_position <= byte_position + OW'(1);
        end
        if (hit) begin
          match_count <= count_inc;
          if (stop_set) begin
            scan_stopped <= 1'b1;
          end
        end
      end
    end
  end

  // Result and output stage.
  mbps_pkg::result_t res;
  mbps_pkg::result_t res_out;

  assign res.match_found  = hit;
  assign res.match_offset = hit ? 32'(first_pos[OW-1:0]) : 32'd0;
  assign res.matched_low  = hit ? matched_all[63:0] : 64'd0;
  assign res.matched_high = hit ? matched_all[127:64] : 64'd0;
  assign res.scan_done    = last_byte;

  mbps_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (in_fire),
    .load_data (res),
    .can_take  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (res_out)
  );

  assign match_found  = res_out.match_found;
  assign match_offset = res_out.match_offset;
  assign matched_low  = res_out.matched_low;
  assign matched_high = res_out.matched_high;
  assign scan_done    = res_out.scan_done;

  // The input side may only stall when a result is already on offer.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result on offer");

  a_hit_counts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && hit && !last_byte) |=> (match_count != '0))
    else $error("reported match was not counted");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && last_byte) |=> ((byte_position == '0) && !scan_stopped &&
                                (match_count == '0)))
    else $error("last byte did not clear the scan state");

endmodule
